### rtl/cmls_pkg.sv
// ----------------------------------------------------------------------------
// cmls_pkg
// Shared types and constants for the categorical mixture log score block.
// ----------------------------------------------------------------------------
package cmls_pkg;

  localparam int unsigned SCORE_FRAC_BITS = 16;
  localparam int unsigned LOG2_FRAC       = 24;
  localparam int unsigned LN_SHIFT        = LOG2_FRAC + 32 - SCORE_FRAC_BITS;
  localparam logic [31:0] LN2_Q32         = 32'd2977044472;
  localparam logic [31:0] ONE_Q32         = 32'hFFFF_FFFF;
  localparam logic [31:0] LOG_MIN         = 32'h8000_0000;

  // term handed from front to back
  typedef struct packed {
    logic [31:0] term;
    logic        is_one;
    logic        last;
  } term_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_NORM,
    B_SQR,
    B_LN,
    B_ACC,
    B_FIN
  } back_state_e;

endpackage

### rtl/cmls_front.sv
// ----------------------------------------------------------------------------
// cmls_front
// Accepts one variable beat, classifies match/mismatch and forms the term.
// ----------------------------------------------------------------------------
module cmls_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      sample_category_i,
  input  logic [7:0]      major_category_i,
  input  logic [15:0]     scatter_q16_i,
  input  logic [7:0]      category_count_i,
  input  logic            last_variable_i,
  output logic            q_push_o,
  input  logic            q_full_i,
  output cmls_pkg::term_t q_data_o
);
  import cmls_pkg::*;

  front_state_e state_q, state_d;
  logic [31:0]  num_q, num_d;    // dividend shifting out, quotient shifting in
  logic [7:0]   rem_q, rem_d;
  logic [7:0]   div_q, div_d;
  logic [4:0]   cnt_q, cnt_d;
  logic         one_q, one_d;
  logic         last_q, last_d;
  logic [8:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    cnt_q  <= cnt_d;
    one_q  <= one_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d  = state_q;
    num_d    = num_q;
    rem_d    = rem_q;
    div_d    = div_q;
    cnt_d    = cnt_q;
    one_d    = one_q;
    last_d   = last_q;
    full_o   = (state_q != F_IDLE);
    q_push_o = 1'b0;
    trial    = {rem_q, num_q[31]};
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          last_d = last_variable_i;
          cnt_d  = '0;
          rem_d  = '0;
          if (sample_category_i == major_category_i) begin
            one_d   = (scatter_q16_i == 16'd0);
            num_d   = {16'd65535 - scatter_q16_i + 16'd1, 16'd0};
            state_d = F_PUSH;
          end else begin
            one_d   = 1'b0;
            num_d   = {scatter_q16_i, 16'd0};
            div_d   = (category_count_i >= 8'd2) ? category_count_i - 8'd1 : 8'd1;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        // remainder stays below the divisor, so it fits 8 bits
        if (trial >= {1'b0, div_q}) begin
          rem_d = 8'(trial - {1'b0, div_q});
          num_d = {num_q[30:0], 1'b1};
        end else begin
          rem_d = trial[7:0];
          num_d = {num_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign q_data_o = '{term: num_q, is_one: one_q, last: last_q};

endmodule

### rtl/cmls_fifo.sv
// ----------------------------------------------------------------------------
// cmls_fifo
// Two-entry term queue between front and back.
// ----------------------------------------------------------------------------
module cmls_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  cmls_pkg::term_t data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output cmls_pkg::term_t data_o
);
  import cmls_pkg::*;

  term_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

### rtl/cmls_back.sv
// ----------------------------------------------------------------------------
// cmls_back
// Takes terms, updates product and log sum, emits the score on last variable.
// ----------------------------------------------------------------------------
module cmls_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            score_mode_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  input  cmls_pkg::term_t q_data_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [31:0]     log_score_o,
  output logic [31:0]     prob_score_o,
  output logic            saturated_o
);
  import cmls_pkg::*;

  back_state_e state_q, state_d;
  term_t       item_q, item_d;
  logic [31:0] log_q, log_d;
  logic [31:0] prod_q, prod_d;
  logic        sat_q, sat_d;
  logic [31:0] y_q, y_d;
  logic [4:0]  sh_q, sh_d;       // normalizing shifts
  logic [4:0]  it_q, it_d;
  logic [23:0] frac_q, frac_d;
  logic [31:0] mag_q, mag_d;
  logic        ov_q, ov_d;       // output valid
  logic [31:0] olog_q, olog_d, oprod_q, oprod_d;
  logic        osat_q, osat_d;

  logic [63:0] pmul, sq;
  logic [32:0] y2;
  logic [29:0] mag2;
  logic [61:0] lnmul;
  logic [33:0] nv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      log_q   <= '0;
      prod_q  <= ONE_Q32;
      sat_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      log_q   <= log_d;
      prod_q  <= prod_d;
      sat_q   <= sat_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    y_q     <= y_d;
    sh_q    <= sh_d;
    it_q    <= it_d;
    frac_q  <= frac_d;
    mag_q   <= mag_d;
    olog_q  <= olog_d;
    oprod_q <= oprod_d;
    osat_q  <= osat_d;
  end

  always_comb begin
    pmul  = {32'd0, prod_q} * {32'd0, (item_q.is_one ? ONE_Q32 : item_q.term)};
    sq    = {32'd0, y_q} * {32'd0, y_q};
    y2    = sq[63:31];
    mag2  = ({25'd0, sh_q} + 30'd1) << LOG2_FRAC;
    mag2  = mag2 - {6'd0, frac_q};
    lnmul = {32'd0, mag2} * {30'd0, LN2_Q32};
    nv    = {{2{log_q[31]}}, log_q} - {2'd0, mag_q};
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    log_d   = log_q;
    prod_d  = prod_q;
    sat_d   = sat_q;
    y_d     = y_q;
    sh_d    = sh_q;
    it_d    = it_q;
    frac_d  = frac_q;
    mag_d   = mag_q;
    ov_d    = ov_q && !pop_i;
    olog_d  = olog_q;
    oprod_d = oprod_q;
    osat_d  = osat_q;
    q_pop_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          state_d = B_PROD;
        end
      end
      B_PROD: begin
        prod_d = pmul[63:32];
        y_d    = item_q.term;
        sh_d   = '0;
        if (item_q.is_one) begin
          state_d = B_FIN;
        end else if (item_q.term == 32'd0) begin
          log_d   = LOG_MIN;
          sat_d   = 1'b1;
          state_d = B_FIN;
        end else begin
          state_d = B_NORM;
        end
      end
      B_NORM: begin
        if (y_q[31]) begin
          it_d    = '0;
          frac_d  = '0;
          state_d = B_SQR;
        end else begin
          y_d  = {y_q[30:0], 1'b0};
          sh_d = sh_q + 5'd1;
        end
      end
      B_SQR: begin
        if (y2[32]) begin
          y_d = y2[32:1];
          frac_d[5'(LOG2_FRAC - 1) - it_q] = 1'b1;
        end else begin
          y_d = y2[31:0];
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(LOG2_FRAC - 1)) state_d = B_LN;
      end
      B_LN: begin
        mag_d   = 32'(lnmul >> LN_SHIFT);
        state_d = B_ACC;
      end
      B_ACC: begin
        if ($signed(nv) < -34'sd2147483648) begin
          log_d = LOG_MIN;
          sat_d = 1'b1;
        end else begin
          log_d = nv[31:0];
        end
        state_d = B_FIN;
      end
      B_FIN: begin
        if (!item_q.last) begin
          state_d = B_IDLE;
        end else if (!ov_q || pop_i) begin
          ov_d    = 1'b1;
          olog_d  = score_mode_i ? 32'd0 : log_q;
          oprod_d = score_mode_i ? prod_q : 32'd0;
          osat_d  = score_mode_i ? 1'b0 : sat_q;
          log_d   = '0;
          prod_d  = ONE_Q32;
          sat_d   = 1'b0;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign empty_o      = !ov_q;
  assign log_score_o  = olog_q;
  assign prob_score_o = oprod_q;
  assign saturated_o  = osat_q;

endmodule

### rtl/categorical_mixture_log_score.sv
// ----------------------------------------------------------------------------
// categorical_mixture_log_score
// Scores a categorical sample against one cluster, one variable per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the variable fields with push_i; a beat is taken
//   when push_i is high and full_o is low. Mark the sample's final variable
//   with last_variable_i.
//   Result channel: one beat per sample, present while empty_o is low,
//   taken with pop_i. log_score_o/saturated_o are valid in log mode,
//   prob_score_o in product mode; the unused fields read 0.
//   Config: cfg_data_i[0] is score_mode, written on cfg_valid_i (always
//   ready). Write it only while the block is idle.
// Operation:
//   Front: a match goes straight to the push state; a mismatch first runs a
//   32-step restoring divider. Back: a 1.0 or zero term skips to the finish
//   state; otherwise up to 31 normalizing shifts, 24 squarings on one 32x32
//   multiplier, one ln2 scaling and one accumulate. The slower of the two
//   loops sets the sustained rate. A two-entry queue decouples the two.
// Reset: accumulators to 0 / all ones, mode to log, queues empty.
// Stall: a held result blocks only the next last-variable beat in the back.
// ----------------------------------------------------------------------------
module categorical_mixture_log_score (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  sample_category_i,
  input  logic [7:0]  major_category_i,
  input  logic [15:0] scatter_q16_i,
  input  logic [7:0]  category_count_i,
  input  logic        last_variable_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] log_score_o,
  output logic [31:0] prob_score_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import cmls_pkg::*;

  logic  mode_q;
  logic  q_push, q_full, q_pop, q_empty;
  term_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  cmls_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_o            (full_o),
    .sample_category_i (sample_category_i),
    .major_category_i  (major_category_i),
    .scatter_q16_i     (scatter_q16_i),
    .category_count_i  (category_count_i),
    .last_variable_i   (last_variable_i),
    .q_push_o          (q_push),
    .q_full_i          (q_full),
    .q_data_o          (q_wdata)
  );

  cmls_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  cmls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .score_mode_i (mode_q),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_data_i     (q_rdata),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .log_score_o  (log_score_o),
    .prob_score_o (prob_score_o),
    .saturated_o  (saturated_o)
  );

  // an accepted beat keeps the front busy next cycle
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !full_o |=> full_o) else $error("front not busy after accept");

  // a saturated score is pinned at the minimum
  a_sat_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && saturated_o |-> log_score_o == LOG_MIN) else $error("sat without min");

  // log score never positive
  a_log_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> log_score_o[31] || log_score_o == 32'd0) else $error("positive log score");

  // held result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(log_score_o) && $stable(prob_score_o))
    else $error("result dropped");

endmodule

### tb/categorical_mixture_log_score_tb.sv
// ----------------------------------------------------------------------------
// categorical_mixture_log_score_tb
// Streams variable beats into the scorer and checks each emitted sample
// score against an in-bench fixed-point predictor, in both score modes.
// ----------------------------------------------------------------------------
module categorical_mixture_log_score_tb;
  import cmls_pkg::*;

  localparam int MAX_ERR_PRINT  = 10;
  localparam int WATCHDOG_LIMIT = 20000; // idle cycles with no beat accepted
  localparam int DRAIN_CYCLES   = 200;   // long enough for the back loop to finish a beat

  typedef enum logic {MODE_LOG = 1'b0, MODE_PROD = 1'b1} score_mode_e;

  typedef struct packed {
    logic [31:0] log_score;
    logic [31:0] prob_score;
    logic        saturated;
  } score_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  sample_category_i = '0;
  logic [7:0]  major_category_i = '0;
  logic [15:0] scatter_q16_i = '0;
  logic [7:0]  category_count_i = '0;
  logic        last_variable_i = 1'b0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [31:0] log_score_o;
  logic [31:0] prob_score_o;
  logic        saturated_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  always #5 clk_i = ~clk_i;

  categorical_mixture_log_score i_dut (
    .clk_i, .rst_ni, .push_i, .full_o,
    .sample_category_i, .major_category_i, .scatter_q16_i,
    .category_count_i, .last_variable_i,
    .empty_o, .pop_i, .log_score_o, .prob_score_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // predictor state
  logic [31:0] acc_log;
  logic [31:0] acc_prod;
  logic        acc_sat;
  score_mode_e cur_mode;
  score_t      score_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int err_cnt;
  int idle_cnt;

  // ln magnitude of t/2^32, unsigned Q.16, truncated
  function automatic logic [63:0] ln_mag(input logic [31:0] t);
    int          msb;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] mag2;
    logic [127:0] wide;
    msb = 31;
    frac = '0;
    while (msb > 0 && !t[msb]) msb--;
    y = 64'(t) << (31 - msb);
    for (int i = 1; i <= LOG2_FRAC; i++) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[LOG2_FRAC - i] = 1'b1;
      end
    end
    mag2 = (64'(32 - msb) << LOG2_FRAC) - frac;
    wide = 128'(mag2) * 128'(LN2_Q32);
    return 64'(wide >> LN_SHIFT);
  endfunction

  // fold one variable into the running scores; queue a score on the last one
  task automatic score_variable(input logic [7:0] samp, input logic [7:0] major,
                                input logic [15:0] s, input logic [7:0] m,
                                input logic last);
    logic        one;
    logic [31:0] t;
    logic [31:0] d;
    logic [63:0] f;
    longint      nv;
    score_t      r;
    one = 1'b0;
    if (samp == major) begin
      one = (s == 16'd0);
      t = (32'd65536 - 32'(s)) << 16;
    end else begin
      d = (m >= 8'd2) ? 32'(m) - 32'd1 : 32'd1;
      t = (32'(s) << 16) / d;
    end
    f = one ? 64'(ONE_Q32) : 64'(t);
    acc_prod = 32'((64'(acc_prod) * f) >> 32);
    if (!one) begin
      if (t == 32'd0) begin
        acc_log = LOG_MIN;
        acc_sat = 1'b1;
      end else begin
        nv = longint'($signed(acc_log)) - longint'(ln_mag(t));
        if (nv < -64'sd2147483648) begin
          nv = -64'sd2147483648;
          acc_sat = 1'b1;
        end
        acc_log = nv[31:0];
      end
    end
    if (last) begin
      if (cur_mode == MODE_LOG) r = '{acc_log, 32'd0, acc_sat};
      else r = '{32'd0, acc_prod, 1'b0};
      score_q.push_back(r);
      acc_log = '0;
      acc_prod = ONE_Q32;
      acc_sat = 1'b0;
    end
  endtask

  // one input beat, with random sender gaps; push stays up for a following beat
  task automatic send_variable(input logic [7:0] samp, input logic [7:0] major,
                               input logic [15:0] s, input logic [7:0] m,
                               input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    sample_category_i <= samp;
    major_category_i <= major;
    scatter_q16_i <= s;
    category_count_i <= m;
    last_variable_i <= last;
    do @(posedge clk_i); while (full_o);
    score_variable(samp, major, s, m, last);
  endtask

  // idle point: wait for all scores, let the back drain, then write the mode
  task automatic set_mode(input score_mode_e mode);
    push_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_mode = mode;
  endtask

  task automatic rand_variable(input logic last);
    logic [7:0]  maj;
    logic [7:0]  samp;
    logic [15:0] s;
    maj = 8'($urandom_range(1, 255));
    samp = ($urandom_range(99) < 60) ? maj : 8'($urandom_range(1, 255));
    case ($urandom_range(9))
      0: s = 16'd0;
      1: s = 16'hFFFF;
      2: s = 16'($urandom_range(15));
      default: s = 16'($urandom);
    endcase
    send_variable(samp, maj, s, 8'($urandom_range(0, 255)), last);
  endtask

  task automatic run_random_samples(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      // mostly short samples, now and then a long one for deep log sums
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) rand_variable(i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_directed(input score_mode_e mode);
    set_mode(mode);
    send_variable(8'd1, 8'd1, 16'd0, 8'd2, 1'b1);          // exact 1.0 only
    send_variable(8'd255, 8'd255, 16'hFFFF, 8'd255, 1'b0); // smallest match term
    send_variable(8'd1, 8'd2, 16'hFFFF, 8'd2, 1'b1);       // mismatch, m = 2
    send_variable(8'd3, 8'd4, 16'd0, 8'd10, 1'b0);         // log of zero
    send_variable(8'd4, 8'd4, 16'd100, 8'd10, 1'b1);
    send_variable(8'd7, 8'd9, 16'h8000, 8'd0, 1'b0);       // count zero
    send_variable(8'd7, 8'd9, 16'h8000, 8'd1, 1'b1);       // count one
    send_variable(8'd0, 8'd255, 16'd1, 8'd255, 1'b0);      // category out of range
    send_variable(8'd0, 8'd0, 16'h5555, 8'd170, 1'b1);
    for (int i = 0; i < 8; i++)                            // chain of tiny terms
      send_variable(8'd1, 8'd2, 16'd1, 8'd255, i == 7);
  endtask

  task automatic test_random(input score_mode_e mode, input int sidle, input int ridle,
                             input int n_items);
    set_mode(mode);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    run_random_samples(n_items);
  endtask

  // receiver stops for a long stretch while samples keep coming
  task automatic test_backpressure();
    set_mode(MODE_LOG);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 3000;
    for (int i = 0; i < 30; i++) rand_variable(1'b1);
  endtask

  // result side: random pops, long hold when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    score_t exp_s;
    if (rst_ni && pop_i && !empty_o) begin
      if (score_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_ERR_PRINT) $display("ERROR: unexpected score beat");
      end else begin
        exp_s = score_q.pop_front();
        if (exp_s.log_score !== log_score_o || exp_s.prob_score !== prob_score_o ||
            exp_s.saturated !== saturated_o) begin
          err_cnt++;
          if (err_cnt <= MAX_ERR_PRINT)
            $display("ERROR: score exp log=%h prob=%h sat=%b got log=%h prob=%h sat=%b",
                     exp_s.log_score, exp_s.prob_score, exp_s.saturated,
                     log_score_o, prob_score_o, saturated_o);
        end
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || hold_cycles > 0) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    idle_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    acc_log = '0;
    acc_prod = ONE_Q32;
    acc_sat = 1'b0;
    cur_mode = MODE_LOG;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed(MODE_LOG);
    test_directed(MODE_PROD);
    test_random(MODE_LOG, 11, 77, 180);
    test_random(MODE_PROD, 77, 11, 180);
    test_random(MODE_LOG, 0, 0, 150);
    test_random(MODE_PROD, 0, 0, 150);
    test_backpressure();
    push_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
